// ----- hw/rtl/pvt_pkg.sv -----
package pvt_pkg;

    // Default number of fraction bits of the normalized screen coordinates.
    localparam int NDC_FRAC_BITS_DEF = 16;

    // Width of world coordinates (room origin plus room-relative corner).
    localparam int COORD_W = 25;
    // Width of one matrix entry (Q20.12).
    localparam int MAT_W = 32;
    // Width of the clip coordinates; the exact sums need 58 bits.
    localparam int CLIP_W = 60;

    // Configuration port.
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;

    // Identity matrix after reset.
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0000_1000,
        64'h0000_0000_0000_0000,
        64'h0000_1000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_1000,
        64'h0000_0000_0000_0000,
        64'h0000_1000_0000_0000
    };

    // Reject reason codes.
    localparam logic [1:0] REASON_VISIBLE = 2'd0;
    localparam logic [1:0] REASON_FACING  = 2'd1;
    localparam logic [1:0] REASON_BEHIND  = 2'd2;
    localparam logic [1:0] REASON_OUTSIDE = 2'd3;

    // Per-corner flags taken from the clip coordinates.
    typedef struct packed {
        logic front;
        logic xneg;
        logic xpos;
        logic yneg;
        logic ypos;
    } lane_side_t;

endpackage

// ----- hw/rtl/pvt_div.sv -----
module pvt_div #(
    parameter int NDC_FRAC_BITS = pvt_pkg::NDC_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic [NDC_FRAC_BITS:0]                 adv,
    input  logic [pvt_pkg::CLIP_W-1:0]             a,
    input  logic [pvt_pkg::CLIP_W-1:0]             d,
    input  logic                                   neg,
    output logic signed [NDC_FRAC_BITS+1:0]        q
);

    localparam int W  = pvt_pkg::CLIP_W;
    localparam int QW = NDC_FRAC_BITS + 1;
    localparam int NW = NDC_FRAC_BITS + 2;
    localparam logic signed [NW-1:0] LIM_POS = NW'((1 << (NDC_FRAC_BITS + 1)) - 1);
    localparam logic signed [NW-1:0] LIM_NEG = NW'(-(1 << (NDC_FRAC_BITS + 1)));

    logic          sat_reg [QW];
    logic          neg_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [W:0]    r_reg   [QW];
    logic [W-1:0]  d_reg   [QW];

    logic           q0;
    logic [NW-1:0]  q_ext;

    // First step: saturation check and the integer quotient bit.
    assign q0 = (a >= d);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sat_reg[0] <= ({1'b0, a} >= {d, 1'b0});
            neg_reg[0] <= neg;
            q_reg[0]   <= QW'(q0);
            r_reg[0]   <= q0 ? {1'b0, a - d} : {1'b0, a};
            d_reg[0]   <= d;
        end
    end

    // One restoring step per stage for each fraction bit.
    for (genvar k = 1; k < QW; k++)
    begin : g_step
        logic [W:0] rs;
        logic       ge;

        assign rs = {r_reg[k-1][W-1:0], 1'b0};
        assign ge = (rs >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                sat_reg[k] <= sat_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                r_reg[k]   <= ge ? rs - {1'b0, d_reg[k-1]} : rs;
                d_reg[k]   <= d_reg[k-1];
            end
        end
    end

    // Apply the sign, or the saturated limit.
    assign q_ext = {1'b0, q_reg[QW-1]};

    always_comb
    begin
        if (sat_reg[QW-1])
            q = neg_reg[QW-1] ? LIM_NEG : LIM_POS;
        else
            q = neg_reg[QW-1] ? -$signed(q_ext) : $signed(q_ext);
    end

endmodule

// ----- hw/rtl/pvt_lane.sv -----
module pvt_lane #(
    parameter int NDC_FRAC_BITS = pvt_pkg::NDC_FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic [NDC_FRAC_BITS+2:0]                 adv,
    input  logic signed [pvt_pkg::COORD_W-1:0]       wx,
    input  logic signed [pvt_pkg::COORD_W-1:0]       wy,
    input  logic signed [pvt_pkg::COORD_W-1:0]       wz,
    input  logic signed [pvt_pkg::MAT_W-1:0]         mcol_x [4],
    input  logic signed [pvt_pkg::MAT_W-1:0]         mcol_y [4],
    input  logic signed [pvt_pkg::MAT_W-1:0]         mcol_w [4],
    output logic signed [NDC_FRAC_BITS+1:0]          nx,
    output logic signed [NDC_FRAC_BITS+1:0]          ny,
    output pvt_pkg::lane_side_t                      side
);

    localparam int CW = pvt_pkg::CLIP_W;
    localparam int PW = pvt_pkg::COORD_W + pvt_pkg::MAT_W;
    localparam int MW = pvt_pkg::MAT_W;
    localparam int QW = NDC_FRAC_BITS + 1;

    logic signed [PW-1:0] prod_x_reg [3];
    logic signed [PW-1:0] prod_y_reg [3];
    logic signed [PW-1:0] prod_w_reg [3];
    logic signed [CW-1:0] px_reg;
    logic signed [CW-1:0] py_reg;
    logic signed [CW-1:0] pw_reg;
    logic signed [CW-1:0] px_next;
    logic signed [CW-1:0] py_next;
    logic signed [CW-1:0] pw_next;
    pvt_pkg::lane_side_t  side_reg [QW];
    pvt_pkg::lane_side_t  side_next;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;

    // Products of the world corner with three matrix columns.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_x_reg[0] <= wx * mcol_x[0];
            prod_x_reg[1] <= wy * mcol_x[1];
            prod_x_reg[2] <= wz * mcol_x[2];
            prod_y_reg[0] <= wx * mcol_y[0];
            prod_y_reg[1] <= wy * mcol_y[1];
            prod_y_reg[2] <= wz * mcol_y[2];
            prod_w_reg[0] <= wx * mcol_w[0];
            prod_w_reg[1] <= wy * mcol_w[1];
            prod_w_reg[2] <= wz * mcol_w[2];
        end
    end

    // Clip coordinates: sum of products plus the translation row.
    assign px_next = {{(CW-PW){prod_x_reg[0][PW-1]}}, prod_x_reg[0]}
                   + {{(CW-PW){prod_x_reg[1][PW-1]}}, prod_x_reg[1]}
                   + {{(CW-PW){prod_x_reg[2][PW-1]}}, prod_x_reg[2]}
                   + {{(CW-MW){mcol_x[3][MW-1]}}, mcol_x[3]};
    assign py_next = {{(CW-PW){prod_y_reg[0][PW-1]}}, prod_y_reg[0]}
                   + {{(CW-PW){prod_y_reg[1][PW-1]}}, prod_y_reg[1]}
                   + {{(CW-PW){prod_y_reg[2][PW-1]}}, prod_y_reg[2]}
                   + {{(CW-MW){mcol_y[3][MW-1]}}, mcol_y[3]};
    assign pw_next = {{(CW-PW){prod_w_reg[0][PW-1]}}, prod_w_reg[0]}
                   + {{(CW-PW){prod_w_reg[1][PW-1]}}, prod_w_reg[1]}
                   + {{(CW-PW){prod_w_reg[2][PW-1]}}, prod_w_reg[2]}
                   + {{(CW-MW){mcol_w[3][MW-1]}}, mcol_w[3]};

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pw_reg <= pw_next;
        end
    end

    // Sign flags travel beside the dividers.
    always_comb
    begin
        side_next.front = (pw_reg > 0);
        side_next.xneg  = px_reg[CW-1];
        side_next.xpos  = !px_reg[CW-1] && (px_reg != '0);
        side_next.yneg  = py_reg[CW-1];
        side_next.ypos  = !py_reg[CW-1] && (py_reg != '0);
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv[k+2])
                side_reg[k] <= (k == 0) ? side_next : side_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign side = side_reg[QW-1];

    // Magnitudes for the dividers; a corner behind the camera is masked later.
    assign ax = px_reg[CW-1] ? -px_reg : px_reg;
    assign ay = py_reg[CW-1] ? -py_reg : py_reg;

    pvt_div #(
        .NDC_FRAC_BITS(NDC_FRAC_BITS)
    ) u_div_x (
        .clk (clk),
        .adv (adv[NDC_FRAC_BITS+2:2]),
        .a   (ax),
        .d   (pw_reg),
        .neg (px_reg[CW-1]),
        .q   (nx)
    );

    pvt_div #(
        .NDC_FRAC_BITS(NDC_FRAC_BITS)
    ) u_div_y (
        .clk (clk),
        .adv (adv[NDC_FRAC_BITS+2:2]),
        .a   (ay),
        .d   (pw_reg),
        .neg (py_reg[CW-1]),
        .q   (ny)
    );

endmodule

// ----- hw/rtl/pvt_merge.sv -----
module pvt_merge #(
    parameter int NDC_FRAC_BITS = pvt_pkg::NDC_FRAC_BITS_DEF
) (
    input  logic signed [NDC_FRAC_BITS+1:0] nx [4],
    input  logic signed [NDC_FRAC_BITS+1:0] ny [4],
    input  pvt_pkg::lane_side_t             side [4],
    input  logic                            facing,
    output logic [1:0]                      reason
);

    localparam int NW = NDC_FRAC_BITS + 2;
    localparam logic signed [NW-1:0] ONE_POS = NW'(1 << NDC_FRAC_BITS);
    localparam logic signed [NW-1:0] ONE_NEG = NW'(-(1 << NDC_FRAC_BITS));
    localparam logic signed [NW-1:0] LIM_POS = NW'((1 << (NDC_FRAC_BITS + 1)) - 1);
    localparam logic signed [NW-1:0] LIM_NEG = NW'(-(1 << (NDC_FRAC_BITS + 1)));

    logic signed [NW-1:0] xmin, xmax, ymin, ymax;
    logic                 set_xmin, set_xmax, set_ymin, set_ymax;
    logic                 any_front, all_front;
    int                   j;

    always_comb
    begin
        xmin = LIM_POS;
        ymin = LIM_POS;
        xmax = LIM_NEG;
        ymax = LIM_NEG;
        set_xmin = 1'b0;
        set_xmax = 1'b0;
        set_ymin = 1'b0;
        set_ymax = 1'b0;
        any_front = 1'b0;
        all_front = 1'b1;
        j = 0;

        // Screen rectangle from the corners in front of the camera.
        for (int i = 0; i < 4; i++)
        begin
            any_front = any_front | side[i].front;
            all_front = all_front & side[i].front;
            if (side[i].front)
            begin
                if (nx[i] < xmin) xmin = nx[i];
                if (ny[i] < ymin) ymin = ny[i];
                if (nx[i] > xmax) xmax = nx[i];
                if (ny[i] > ymax) ymax = ny[i];
            end
        end

        // Edges that cross the camera plane open the rectangle to the screen edges.
        for (int i = 0; i < 4; i++)
        begin
            j = (i + 1) % 4;
            if (side[i].front != side[j].front)
            begin
                if (side[i].xneg && side[j].xneg)
                    set_xmin = 1'b1;
                else if (side[i].xpos && side[j].xpos)
                    set_xmax = 1'b1;
                else
                begin
                    set_xmin = 1'b1;
                    set_xmax = 1'b1;
                end
                if (side[i].yneg && side[j].yneg)
                    set_ymin = 1'b1;
                else if (side[i].ypos && side[j].ypos)
                    set_ymax = 1'b1;
                else
                begin
                    set_ymin = 1'b1;
                    set_ymax = 1'b1;
                end
            end
        end

        if (!all_front)
        begin
            if (set_xmin) xmin = ONE_NEG;
            if (set_xmax) xmax = ONE_POS;
            if (set_ymin) ymin = ONE_NEG;
            if (set_ymax) ymax = ONE_POS;
        end

        // Clamp to the screen.
        if (xmin < ONE_NEG) xmin = ONE_NEG;
        if (ymin < ONE_NEG) ymin = ONE_NEG;
        if (xmax > ONE_POS) xmax = ONE_POS;
        if (ymax > ONE_POS) ymax = ONE_POS;

        if (!facing)
            reason = pvt_pkg::REASON_FACING;
        else if (!any_front)
            reason = pvt_pkg::REASON_BEHIND;
        else if (xmin > ONE_POS || ymin > ONE_POS || xmax < ONE_NEG || ymax < ONE_NEG)
            reason = pvt_pkg::REASON_OUTSIDE;
        else
            reason = pvt_pkg::REASON_VISIBLE;
    end

endmodule

// ----- hw/rtl/portal_visibility_test.sv -----
// Channel   Direction  Handshake             Words
// input     in         in_valid / in_stall   camera, room origin, normal, four corners
// output    out        out_valid / out_stall visible, reject_reason
// config    in         cfg_valid / cfg_ready matrix register index and 64-bit data
//
// One portal word is accepted per cycle while in_stall is low.
// The path runs through the four corner lanes: input register, multiply, sum, and one
// restoring divider stage per quotient bit, then the merge into the output register.
// Each stage holds its word while the next cannot take it; bubbles close up under stall.
// Reset clears all valid bits and loads the identity matrix; cfg_ready is always high.
module portal_visibility_test #(
    parameter int NDC_FRAC_BITS = pvt_pkg::NDC_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [23:0]                  cam_x,
    input  logic signed [23:0]                  cam_y,
    input  logic signed [23:0]                  cam_z,
    input  logic signed [23:0]                  room_x,
    input  logic signed [23:0]                  room_y,
    input  logic signed [23:0]                  room_z,
    input  logic [47:0]                         normal_packed,
    input  logic [47:0]                         corner_a,
    input  logic [47:0]                         corner_b,
    input  logic [47:0]                         corner_c,
    input  logic [47:0]                         corner_d,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                visible,
    output logic [1:0]                          reject_reason,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pvt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pvt_pkg::CFG_W-1:0]           cfg_data
);

    localparam int NS = NDC_FRAC_BITS + 4;
    localparam int CW = pvt_pkg::COORD_W;
    localparam int MW = pvt_pkg::MAT_W;
    localparam int DW = CW + 1;
    localparam int PW = DW + 16;
    localparam int SW = PW + 2;
    localparam int NW = NDC_FRAC_BITS + 2;

    logic [pvt_pkg::CFG_W-1:0] cfg_reg [pvt_pkg::NUM_CFG];
    logic [NS-1:0]             v_reg;
    logic [NS:0]               rdy;
    logic                      out_valid_reg;
    logic                      visible_reg;
    logic [1:0]                reason_reg;
    logic [1:0]                reason_next;

    logic signed [23:0]        cam_reg  [3];
    logic signed [23:0]        room_reg [3];
    logic [47:0]               normal_reg;
    logic [47:0]               corner_reg [4];

    logic signed [CW-1:0]      wp [4][3];
    logic signed [DW-1:0]      diff [3];
    logic signed [PW-1:0]      dprod_reg [3];
    logic                      fac_reg [NS-1:2];

    logic signed [MW-1:0]      mcol_x [4];
    logic signed [MW-1:0]      mcol_y [4];
    logic signed [MW-1:0]      mcol_w [4];
    logic signed [NW-1:0]      nx [4];
    logic signed [NW-1:0]      ny [4];
    pvt_pkg::lane_side_t       side [4];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pvt_pkg::NUM_CFG; i++)
                cfg_reg[i] <= pvt_pkg::CFG_RESET[i];
        end
        else if (cfg_valid && cfg_index < pvt_pkg::CFG_IDX_W'(pvt_pkg::NUM_CFG))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Matrix columns x, y and w; row 3 is the translation.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mcol_x[r] = cfg_reg[2*r][31:0];
            mcol_y[r] = cfg_reg[2*r][63:32];
            mcol_w[r] = cfg_reg[2*r+1][63:32];
        end
    end

    // Stage ready chain: a stage loads when it is empty or its successor moves on.
    always_comb
    begin
        rdy[NS] = !out_valid_reg || !out_stall;
        for (int k = NS - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_stall = !rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
            if (rdy[NS])
                out_valid_reg <= v_reg[NS-1];
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            cam_reg[0]    <= cam_x;
            cam_reg[1]    <= cam_y;
            cam_reg[2]    <= cam_z;
            room_reg[0]   <= room_x;
            room_reg[1]   <= room_y;
            room_reg[2]   <= room_z;
            normal_reg    <= normal_packed;
            corner_reg[0] <= corner_a;
            corner_reg[1] <= corner_b;
            corner_reg[2] <= corner_c;
            corner_reg[3] <= corner_d;
        end
    end

    // World corners and the camera offset from the first corner.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                wp[i][k] = {room_reg[k][23], room_reg[k]}
                         + {{(CW-16){corner_reg[i][16*k+15]}}, corner_reg[i][16*k +: 16]};
            end
        end
        for (int k = 0; k < 3; k++)
            diff[k] = {{2{cam_reg[k][23]}}, cam_reg[k]} - {wp[0][k][CW-1], wp[0][k]};
    end

    // Back-face test: products, then the signed sum.
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int k = 0; k < 3; k++)
                dprod_reg[k] <= $signed(normal_reg[16*k +: 16]) * diff[k];
        end
        if (rdy[2])
        begin
            fac_reg[2] <= $signed({{2{dprod_reg[0][PW-1]}}, dprod_reg[0]}
                                + {{2{dprod_reg[1][PW-1]}}, dprod_reg[1]}
                                + {{2{dprod_reg[2][PW-1]}}, dprod_reg[2]}) > SW'(0);
        end
    end

    for (genvar k = 3; k < NS; k++)
    begin : g_fac
        always_ff @(posedge clk)
        begin
            if (rdy[k])
                fac_reg[k] <= fac_reg[k-1];
        end
    end

    // One projection and divide lane per corner.
    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        pvt_lane #(
            .NDC_FRAC_BITS(NDC_FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .adv    (rdy[NS-1:1]),
            .wx     (wp[i][0]),
            .wy     (wp[i][1]),
            .wz     (wp[i][2]),
            .mcol_x (mcol_x),
            .mcol_y (mcol_y),
            .mcol_w (mcol_w),
            .nx     (nx[i]),
            .ny     (ny[i]),
            .side   (side[i])
        );
    end

    // Merge the four lanes into one verdict.
    pvt_merge #(
        .NDC_FRAC_BITS(NDC_FRAC_BITS)
    ) u_merge (
        .nx     (nx),
        .ny     (ny),
        .side   (side),
        .facing (fac_reg[NS-1]),
        .reason (reason_next)
    );

    // Output register.
    always_ff @(posedge clk)
    begin
        if (rdy[NS])
        begin
            reason_reg  <= reason_next;
            visible_reg <= (reason_next == pvt_pkg::REASON_VISIBLE);
        end
    end

    assign out_valid     = out_valid_reg;
    assign visible       = visible_reg;
    assign reject_reason = reason_reg;

    // The visible flag agrees with the reason code.
    a_visible_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (visible_reg == (reason_reg == pvt_pkg::REASON_VISIBLE)))
        else $error("visible flag disagrees with reject reason");

    // With nothing in the last stage, a taken result leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !v_reg[NS-1]) |=> !out_valid_reg)
        else $error("result repeated");

    // A word in the first stage that cannot move is kept.
    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !rdy[1]) |=> v_reg[0])
        else $error("word lost in first stage");

endmodule
